@@ sv/circular_spacing_run_scorer_macros.svh @@
// Assertion macros shared by the RTL files of the spacing run scorer.
// Each macro checks on the rising edge of the given clock and is disabled
// while the given active-low reset is asserted.
`ifndef CIRCULAR_SPACING_RUN_SCORER_MACROS_SVH
`define CIRCULAR_SPACING_RUN_SCORER_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every clock edge outside reset.
`define CSRS_ASSERT_ALWAYS(label, clock, reset_n, prop) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (prop)) \
        else $error("assertion failed");

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define CSRS_ASSERT_IMPLY(label, clock, reset_n, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |-> (cons)) \
        else $error("implication failed");

// Whenever the antecedent holds, the consequent must hold in the next cycle.
`define CSRS_ASSERT_NEXT(label, clock, reset_n, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define CSRS_ASSERT_ALWAYS(label, clock, reset_n, prop)
`define CSRS_ASSERT_IMPLY(label, clock, reset_n, ante, cons)
`define CSRS_ASSERT_NEXT(label, clock, reset_n, ante, cons)

`endif

`endif

@@ sv/csrs_pkg.sv @@
`timescale 1ns / 1ps

package csrs_pkg;

    // Store and field sizes.
    localparam int MAX_ANGLES = 64;
    localparam int ANGLE_BITS = 16;
    localparam int COUNT_W    = $clog2(MAX_ANGLES + 1);
    localparam int IDX_W      = $clog2(MAX_ANGLES);
    localparam int STEP_W     = $clog2(2 * MAX_ANGLES);
    localparam int GAP_W      = ANGLE_BITS + 1;
    localparam int TOL_W      = 16;
    localparam int RUN_W      = 8;

    // Stream data widths, rounded up to whole bytes.
    localparam int IN_TDATA_W  = ((ANGLE_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_W = RUN_W + 1;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // Constants of the scoring rule.
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(364);
    localparam logic [RUN_W-1:0] RUN_LIMIT = RUN_W'(255);
    localparam logic [RUN_W-1:0] RUN_ONE   = RUN_W'(1);
    localparam logic [GAP_W-1:0] FULL_TURN = GAP_W'(1) << ANGLE_BITS;

    // Operation broadcast to every cell of the sorting chain.
    typedef struct packed {
        logic insert;
        logic rotate;
    } cell_ctrl_t;

    // One gap handed from the chain head to the run scorer.
    typedef struct packed {
        logic             valid;
        logic             init;
        logic [GAP_W-1:0] gap;
    } gap_beat_t;

endpackage

@@ sv/circular_spacing_run_scorer.sv @@
`timescale 1ns / 1ps

// Circular spacing run scorer. Angles (fractions of a turn, 65536 = one turn)
// arrive one transaction per cycle and drop into a chain of insertion-sort cells
// that keeps them in ascending order; up to 64 are held and later ones are
// dropped and reported as overflow. The transaction marked tlast closes the set:
// the chain then rotates its n angles past its head, one per cycle, and a run
// scorer forms the circular gaps and tracks the longest run of gaps within
// gap_tolerance of the gap that opened the run, over the gap list taken twice.
// While collecting, an angle is taken every cycle. After the closing angle the
// input is held off through the rotation of the cell chain (one gap per cycle),
// the pipeline flush and the result handoff, and longer if the previous result
// has not yet been taken. The store needs no clearing after reset. Write
// gap_tolerance only while the block is idle.

`include "circular_spacing_run_scorer_macros.svh"

module circular_spacing_run_scorer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration: gap_tolerance.
    input  logic                                 cfg_we,
    input  logic [csrs_pkg::TOL_W-1:0]           cfg_data,
    // Input stream. tdata: angle [15:0].
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [csrs_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                 s_tlast,
    // Result stream. tdata: longest_run [7:0], overflow [8], zero [15:9].
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [csrs_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import csrs_pkg::*;

    typedef enum logic [1:0] {
        S_COLLECT,
        S_SCAN,
        S_FLUSH,
        S_DONE
    } state_t;

    state_t                  state_reg;
    logic [TOL_W-1:0]        tol_reg;
    logic [COUNT_W-1:0]      count_reg;
    logic [ANGLE_BITS-1:0]   max_reg;
    logic [ANGLE_BITS-1:0]   prev_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic                    ovf_seen_reg;
    logic                    ovf_result_reg;
    gap_beat_t               beat_reg;
    logic                    m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg;

    logic                    s_accept;
    logic                    store_full;
    logic [ANGLE_BITS-1:0]   angle;
    logic [ANGLE_BITS-1:0]   max_next;
    cell_ctrl_t              cell_ctrl;
    logic [ANGLE_BITS-1:0]   cell_value [MAX_ANGLES];
    logic                    cell_gt [MAX_ANGLES];
    logic [ANGLE_BITS-1:0]   head;
    logic [GAP_W-1:0]        gap;
    logic                    idx_last;
    logic                    step_last;
    logic [RUN_W-1:0]        best_run;

    assign angle      = s_tdata[ANGLE_BITS-1:0];
    assign s_tready   = (state_reg == S_COLLECT);
    assign s_accept   = s_tvalid && s_tready;
    assign store_full = (count_reg == COUNT_W'(MAX_ANGLES));

    // Largest angle of the set, which is the tail of the sorted chain.
    assign max_next = ((count_reg == '0) || (angle > max_reg)) ? angle : max_reg;

    assign cell_ctrl.insert = s_accept && !store_full;
    assign cell_ctrl.rotate = (state_reg == S_SCAN);

    // Insertion-sort cell chain.
    assign head = cell_value[0];

    for (genvar i = 0; i < MAX_ANGLES; i++)
    begin : g_cell
        logic [ANGLE_BITS-1:0] prev_value;
        logic                  prev_gt;
        logic [ANGLE_BITS-1:0] next_value;

        if (i == 0)
        begin : g_first
            assign prev_value = angle;
            assign prev_gt    = 1'b0;
        end
        else
        begin : g_inner
            assign prev_value = cell_value[i-1];
            assign prev_gt    = cell_gt[i-1];
        end

        if (i == MAX_ANGLES - 1)
        begin : g_end
            assign next_value = head;
        end
        else
        begin : g_mid
            assign next_value = cell_value[i+1];
        end

        csrs_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .angle_in   (angle),
            .prev_value (prev_value),
            .prev_gt    (prev_gt),
            .next_value (next_value),
            .head_value (head),
            .is_valid   (count_reg > COUNT_W'(i)),
            .is_tail    (count_reg == COUNT_W'(i + 1)),
            .value      (cell_value[i]),
            .gt         (cell_gt[i])
        );
    end

    // Gap ending at the head angle; at sorted index zero it wraps a full turn.
    assign gap = {1'b0, head} - {1'b0, prev_reg} + ((idx_reg == '0) ? FULL_TURN : '0);

    assign idx_last  = ({1'b0, idx_reg} == (count_reg - COUNT_W'(1)));
    assign step_last = ({1'b0, step_reg} + (STEP_W + 1)'(1)) == {count_reg, 1'b0};

    // Run scorer.
    csrs_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (beat_reg),
        .tolerance (tol_reg),
        .best_run  (best_run)
    );

    // Control, collection state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_COLLECT;
            tol_reg        <= TOL_RESET;
            count_reg      <= '0;
            max_reg        <= '0;
            prev_reg       <= '0;
            step_reg       <= '0;
            idx_reg        <= '0;
            ovf_seen_reg   <= 1'b0;
            ovf_result_reg <= 1'b0;
            beat_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                tol_reg <= cfg_data;
            end

            // Result valid rises when a score is loaded and drops once it is taken.
            if ((state_reg == S_DONE) && (!m_tvalid_reg || m_tready))
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            // A gap beat goes to the scorer on every scan cycle.
            beat_reg.valid <= (state_reg == S_SCAN);

            unique case (state_reg)
                S_COLLECT:
                begin
                    if (s_accept)
                    begin
                        if (!store_full)
                        begin
                            count_reg <= count_reg + COUNT_W'(1);
                            max_reg   <= max_next;
                        end
                        if (s_tlast)
                        begin
                            ovf_result_reg <= ovf_seen_reg || store_full;
                            ovf_seen_reg   <= 1'b0;
                            prev_reg       <= store_full ? max_reg : max_next;
                            step_reg       <= '0;
                            idx_reg        <= '0;
                            state_reg      <= S_SCAN;
                        end
                        else if (store_full)
                        begin
                            ovf_seen_reg <= 1'b1;
                        end
                    end
                end
                S_SCAN:
                begin
                    beat_reg.init  <= (step_reg == '0);
                    beat_reg.gap   <= gap;
                    prev_reg       <= head;
                    step_reg       <= step_reg + STEP_W'(1);
                    idx_reg        <= idx_last ? '0 : idx_reg + IDX_W'(1);
                    if (step_last)
                    begin
                        state_reg <= S_FLUSH;
                    end
                end
                S_FLUSH:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= OUT_TDATA_W'({ovf_result_reg, best_run});
                        count_reg    <= '0;
                        state_reg    <= S_COLLECT;
                    end
                end
                default:
                begin
                    state_reg <= S_COLLECT;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A scan always has at least one angle and never runs past 2n gaps.
    `CSRS_ASSERT_IMPLY(a_scan_has_angles, clk, rst_n, state_reg == S_SCAN, count_reg != '0)
    `CSRS_ASSERT_ALWAYS(a_count_in_range, clk, rst_n, count_reg <= COUNT_W'(MAX_ANGLES))
    `CSRS_ASSERT_IMPLY(a_step_bounded, clk, rst_n, state_reg == S_SCAN,
        ({1'b0, step_reg} < {count_reg, 1'b0}) && ({1'b0, idx_reg} < count_reg))

endmodule

@@ sv/csrs_cell.sv @@
`timescale 1ns / 1ps

module csrs_cell (
    input  logic                               clk,
    input  csrs_pkg::cell_ctrl_t               ctrl,
    input  logic [csrs_pkg::ANGLE_BITS-1:0]    angle_in,
    input  logic [csrs_pkg::ANGLE_BITS-1:0]    prev_value,
    input  logic                               prev_gt,
    input  logic [csrs_pkg::ANGLE_BITS-1:0]    next_value,
    input  logic [csrs_pkg::ANGLE_BITS-1:0]    head_value,
    input  logic                               is_valid,
    input  logic                               is_tail,
    output logic [csrs_pkg::ANGLE_BITS-1:0]    value,
    output logic                               gt
);
    import csrs_pkg::*;

    logic [ANGLE_BITS-1:0] value_reg;
    logic [ANGLE_BITS-1:0] value_next;

    // An empty cell counts as larger than any incoming angle.
    assign gt    = !is_valid || (value_reg > angle_in);
    assign value = value_reg;

    // Insert: cells above the new angle shift up by one, the first of them takes
    // the new angle. Rotate: each cell takes its upper neighbor, the tail takes
    // the head, so the sorted set circulates past the head.
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert)
        begin
            if (gt)
            begin
                value_next = prev_gt ? prev_value : angle_in;
            end
        end
        else if (ctrl.rotate)
        begin
            value_next = is_tail ? head_value : next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

@@ sv/csrs_scan.sv @@
`timescale 1ns / 1ps

`include "circular_spacing_run_scorer_macros.svh"

module csrs_scan (
    input  logic                           clk,
    input  logic                           rst_n,
    input  csrs_pkg::gap_beat_t            beat,
    input  logic [csrs_pkg::TOL_W-1:0]     tolerance,
    output logic [csrs_pkg::RUN_W-1:0]     best_run
);
    import csrs_pkg::*;

    logic [GAP_W-1:0] ref_gap_reg;
    logic [GAP_W-1:0] ref_gap_next;
    logic [RUN_W-1:0] cur_run_reg;
    logic [RUN_W-1:0] cur_run_next;
    logic [RUN_W-1:0] best_run_reg;
    logic [RUN_W-1:0] best_run_next;
    logic [GAP_W-1:0] gap_diff;
    logic             gap_match;

    // Distance between this gap and the gap that opened the run.
    assign gap_diff  = (beat.gap >= ref_gap_reg) ? (beat.gap - ref_gap_reg)
                                                 : (ref_gap_reg - beat.gap);
    assign gap_match = gap_diff <= GAP_W'(tolerance);

    // The opening beat seeds the run; later beats extend or restart it.
    always_comb
    begin
        ref_gap_next  = ref_gap_reg;
        cur_run_next  = cur_run_reg;
        best_run_next = best_run_reg;
        if (beat.valid)
        begin
            if (beat.init)
            begin
                ref_gap_next  = beat.gap;
                cur_run_next  = RUN_ONE;
                best_run_next = RUN_ONE;
            end
            else
            begin
                if (gap_match)
                begin
                    if (cur_run_reg < RUN_LIMIT)
                    begin
                        cur_run_next = cur_run_reg + RUN_ONE;
                    end
                end
                else
                begin
                    cur_run_next = RUN_ONE;
                    ref_gap_next = beat.gap;
                end
                if (cur_run_next > best_run_reg)
                begin
                    best_run_next = cur_run_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_gap_reg  <= '0;
            cur_run_reg  <= RUN_ONE;
            best_run_reg <= RUN_ONE;
        end
        else
        begin
            ref_gap_reg  <= ref_gap_next;
            cur_run_reg  <= cur_run_next;
            best_run_reg <= best_run_next;
        end
    end

    assign best_run = best_run_reg;

    // The best run always covers the current one, and neither drops to zero.
    `CSRS_ASSERT_ALWAYS(a_cur_within_best, clk, rst_n, cur_run_reg <= best_run_reg)
    `CSRS_ASSERT_ALWAYS(a_run_nonzero, clk, rst_n, (cur_run_reg != '0) && (best_run_reg != '0))
    `CSRS_ASSERT_NEXT(a_init_restarts, clk, rst_n, beat.valid && beat.init,
        (cur_run_reg == RUN_ONE) && (best_run_reg == RUN_ONE))

endmodule
